[design/hrhp_pkg.sv]
`default_nettype none

package hrhp_pkg;

  // Fixed sizing of the parser.
  localparam int MAX_HEADERS = 64;
  localparam int POS_W       = 16;
  localparam int LINE_W      = 12;
  localparam int HCOUNT_W    = 7;
  localparam int HINDEX_W    = 6;
  localparam int CFG_IDX_W   = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LINE_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_LIMIT = 2'd1;

  localparam logic [LINE_W-1:0]   LINE_LIMIT_RESET   = 12'd1024;
  localparam logic [HCOUNT_W-1:0] HEADER_LIMIT_RESET = 7'd64;

  // Event codes reported with every byte.
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_METHOD   = 3'd1;
  localparam logic [2:0] EV_URI      = 3'd2;
  localparam logic [2:0] EV_VERSION  = 3'd3;
  localparam logic [2:0] EV_HEADER   = 3'd4;
  localparam logic [2:0] EV_COMPLETE = 3'd5;
  localparam logic [2:0] EV_ERROR    = 3'd6;

  // Characters of the request grammar.
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Parser phases, one-hot.
  typedef enum logic [5:0] {
    PH_METHOD   = 6'b000001,
    PH_URI      = 6'b000010,
    PH_VERSION  = 6'b000100,
    PH_HEADER   = 6'b001000,
    PH_COMPLETE = 6'b010000,
    PH_ERROR    = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_request;
  } in_item_t;

  typedef struct packed {
    logic [2:0]          event_res;
    logic [POS_W-1:0]    field_start;
    logic [POS_W-1:0]    field_length;
    logic [LINE_W-1:0]   key_length;
    logic                has_colon;
    logic [HINDEX_W-1:0] header_index;
    logic [POS_W-1:0]    position;
  } out_item_t;

  typedef struct packed {
    logic [LINE_W-1:0]   line_limit;
    logic [HCOUNT_W-1:0] header_limit;
  } cfg_regs_t;

  // Expected bytes of "GET ".
  function automatic logic [7:0] method_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = CH_G;
      2'd1:    c = CH_E;
      2'd2:    c = CH_T;
      default: c = CH_SPACE;
    endcase
    return c;
  endfunction

  // Expected bytes of "HTTP/1.0" CR LF; the minor digit is checked apart.
  function automatic logic [7:0] version_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = CH_H;
      4'd1:    c = CH_T;
      4'd2:    c = CH_T;
      4'd3:    c = CH_P;
      4'd4:    c = CH_SLASH;
      4'd5:    c = CH_ONE;
      4'd6:    c = CH_DOT;
      4'd7:    c = CH_ZERO;
      4'd8:    c = CH_CR;
      default: c = CH_LF;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[design/hrhp_parser.sv]
`default_nettype none

module hrhp_parser (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire hrhp_pkg::cfg_regs_t cfg,
  input  wire hrhp_pkg::in_item_t  item,
  input  wire logic               step,
  output hrhp_pkg::out_item_t     result
);
  import hrhp_pkg::*;

  // Parser state.
  phase_t              phase, phase_next;
  logic [POS_W-1:0]    byte_position, byte_position_next;
  logic [POS_W-1:0]    token_start, token_start_next;
  logic [3:0]          match_index, match_index_next;
  logic [LINE_W-1:0]   colon_offset, colon_offset_next;
  logic                colon_seen, colon_seen_next;
  logic [HCOUNT_W-1:0] header_count, header_count_next;
  logic                pending_cr, pending_cr_next;
  logic [LINE_W-1:0]   line_length, line_length_next;

  // State as seen by this byte, after an optional restart.
  phase_t              cur_phase;
  logic [POS_W-1:0]    pos, pos_inc, cur_tstart, uri_len;
  logic [3:0]          cur_midx;
  logic [LINE_W-1:0]   cur_coff, cur_llen, work_llen;
  logic                cur_cseen, cur_pcr, err;
  logic [HCOUNT_W-1:0] cur_hcnt, hdr_lim;
  logic [7:0]          b;

  assign b = item.data_byte;

  always_comb begin
    cur_phase  = item.new_request ? PH_METHOD : phase;
    pos        = item.new_request ? '0 : byte_position;
    cur_tstart = item.new_request ? '0 : token_start;
    cur_midx   = item.new_request ? '0 : match_index;
    cur_coff   = item.new_request ? '0 : colon_offset;
    cur_cseen  = item.new_request ? 1'b0 : colon_seen;
    cur_hcnt   = item.new_request ? '0 : header_count;
    cur_pcr    = item.new_request ? 1'b0 : pending_cr;
    cur_llen   = item.new_request ? '0 : line_length;

    pos_inc  = pos + 1'b1;
    uri_len  = pos - cur_tstart;
    hdr_lim  = (cfg.header_limit < HCOUNT_W'(MAX_HEADERS)) ? cfg.header_limit
                                                            : HCOUNT_W'(MAX_HEADERS);
    work_llen = cur_llen + LINE_W'(cur_pcr);

    phase_next        = cur_phase;
    token_start_next  = cur_tstart;
    match_index_next  = cur_midx;
    colon_offset_next = cur_coff;
    colon_seen_next   = cur_cseen;
    header_count_next = cur_hcnt;
    pending_cr_next   = cur_pcr;
    line_length_next  = cur_llen;
    byte_position_next = pos_inc;

    result              = '0;
    result.event_res    = EV_NONE;
    result.position     = pos;
    err                 = 1'b0;

    unique case (cur_phase) inside
      PH_METHOD: begin
        if (cur_midx > 4'd3 || b != method_char(cur_midx[1:0])) begin
          err = 1'b1;
        end else if (cur_midx == 4'd3) begin
          result.event_res    = EV_METHOD;
          result.field_start  = cur_tstart;
          result.field_length = POS_W'(3);
          phase_next          = PH_URI;
          token_start_next    = pos_inc;
          match_index_next    = '0;
        end else begin
          match_index_next = cur_midx + 1'b1;
        end
      end
      PH_URI: begin
        if (pos >= POS_W'(cfg.line_limit) || b == CH_CR || b == CH_LF) begin
          err = 1'b1;
        end else if (b == CH_SPACE) begin
          if (uri_len == '0) begin
            err = 1'b1;
          end else begin
            result.event_res    = EV_URI;
            result.field_start  = cur_tstart;
            result.field_length = uri_len;
            phase_next          = PH_VERSION;
            token_start_next    = pos_inc;
            match_index_next    = '0;
          end
        end
      end
      PH_VERSION: begin
        if (cur_midx > 4'd9) begin
          err = 1'b1;
        end else if ((cur_midx == 4'd7) ? (b != CH_ZERO && b != CH_ONE)
                                        : (b != version_char(cur_midx))) begin
          err = 1'b1;
        end else if (cur_midx == 4'd9) begin
          result.event_res    = EV_VERSION;
          result.field_start  = cur_tstart;
          result.field_length = POS_W'(8);
          phase_next          = PH_HEADER;
          match_index_next    = '0;
          header_count_next   = '0;
          token_start_next    = pos_inc;
          line_length_next    = '0;
          colon_offset_next   = '0;
          colon_seen_next     = 1'b0;
          pending_cr_next     = 1'b0;
        end else begin
          match_index_next = cur_midx + 1'b1;
        end
      end
      PH_HEADER: begin
        if (cur_pcr && b == CH_LF) begin
          // CR LF closes the line; an empty line closes the request.
          if (cur_llen == '0) begin
            result.event_res    = EV_COMPLETE;
            result.field_start  = '0;
            result.field_length = pos_inc;
            phase_next          = PH_COMPLETE;
          end else if ({1'b0, cur_hcnt} + 8'd1 > {1'b0, hdr_lim}) begin
            err = 1'b1;
          end else begin
            result.event_res    = EV_HEADER;
            result.field_start  = cur_tstart;
            result.field_length = POS_W'(cur_llen);
            result.key_length   = cur_cseen ? cur_coff : '0;
            result.has_colon    = cur_cseen;
            result.header_index = cur_hcnt[HINDEX_W-1:0];
            header_count_next   = cur_hcnt + 1'b1;
            token_start_next    = pos_inc;
            line_length_next    = '0;
            colon_offset_next   = '0;
            colon_seen_next     = 1'b0;
            pending_cr_next     = 1'b0;
          end
        end else begin
          // A CR not followed by LF counts as a content byte.
          pending_cr_next  = 1'b0;
          line_length_next = work_llen;
          if (work_llen >= cfg.line_limit) begin
            err = 1'b1;
          end else begin
            if (b == CH_COLON && !cur_cseen) begin
              colon_offset_next = work_llen;
              colon_seen_next   = 1'b1;
            end
            if (b == CH_CR) begin
              pending_cr_next = 1'b1;
            end else begin
              line_length_next = work_llen + 1'b1;
            end
          end
        end
      end
      PH_COMPLETE, PH_ERROR: begin
      end
      default: begin
      end
    endcase

    // An error is reported once, then the parser stays silent.
    if (err) begin
      phase_next          = PH_ERROR;
      result              = '0;
      result.event_res    = EV_ERROR;
      result.field_start  = pos;
      result.position     = pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_METHOD;
      byte_position <= '0;
      token_start   <= '0;
      match_index   <= '0;
      colon_offset  <= '0;
      colon_seen    <= 1'b0;
      header_count  <= '0;
      pending_cr    <= 1'b0;
      line_length   <= '0;
    end else if (step) begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      token_start   <= token_start_next;
      match_index   <= match_index_next;
      colon_offset  <= colon_offset_next;
      colon_seen    <= colon_seen_next;
      header_count  <= header_count_next;
      pending_cr    <= pending_cr_next;
      line_length   <= line_length_next;
    end
  end

  // An error byte must leave the parser in the error phase.
  a_error_sticks: assert property (@(posedge clk) disable iff (rst)
    step && result.event_res == EV_ERROR |=> phase == PH_ERROR)
    else $error("error event did not enter error phase");

  // Completion reports the whole header length from offset zero.
  a_complete_len: assert property (@(posedge clk) disable iff (rst)
    step && result.event_res == EV_COMPLETE |->
      result.field_start == '0 && result.field_length == result.position + 1'b1)
    else $error("complete event has wrong bounds");

  // The header count never passes the hard ceiling.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    header_count <= HCOUNT_W'(MAX_HEADERS))
    else $error("header count above ceiling");

endmodule

`default_nettype wire

[design/http_request_header_parser_top.sv]
`default_nettype none

// HTTP request header parser. Takes one request byte per transaction on the
// input channel and returns exactly one result per byte: the event that byte
// caused (method, URI, version, header line, headers complete, error or none),
// the bounds of the field it closed and the byte's own offset. Throughput is
// one byte per clock while the output is not stalled. Each byte is held in
// the input register, and the parser state update that follows it loads the
// result register. Setting new_request on a byte restarts parsing at that
// byte. Errors and completion are sticky until then.
// line_limit (index 0) and header_limit (index 1) must be written through the
// configuration channel only while no bytes are in flight; the block itself
// does not enforce this.
module http_request_header_parser_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire hrhp_pkg::in_item_t                 in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output hrhp_pkg::out_item_t                    out_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [hrhp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [hrhp_pkg::LINE_W-1:0]       cfg_data
);
  import hrhp_pkg::*;

  cfg_regs_t cfg;
  in_item_t  in_q;
  out_item_t result;
  logic      in_full;
  logic      advance;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_limit   <= LINE_LIMIT_RESET;
      cfg.header_limit <= HEADER_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LINE_LIMIT:   cfg.line_limit   <= cfg_data;
        REG_HEADER_LIMIT: cfg.header_limit <= cfg_data[HCOUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The held byte moves into the parser when the result slot frees up.
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
  end

  hrhp_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (in_q),
    .step   (advance),
    .result (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  // An empty input register never blocks the input.
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !in_full |-> in_ready)
    else $error("input blocked while empty");

  // A new result only appears after the parser stepped.
  a_out_from_step: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(advance))
    else $error("result appeared without a parser step");

  // A stepped byte always lands in the result register.
  a_step_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("parser step lost its result");

endmodule

`default_nettype wire
